// ----- sv/ordered_list_append_delete_walk_defines.svh -----
// assertion macros used by the checker file of the ordered list block
// no dependencies; take in with `include before use
`ifndef ORDERED_LIST_APPEND_DELETE_WALK_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_WALK_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define OLADW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define OLADW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/olist_pkg.sv -----
// types and codes of the ordered list block
// no dependencies; used by every module of the block by scoped names
package olist_pkg;

  localparam int unsigned DATA_W = 32;

  // request codes
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_WALK   = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_FWD        = 3'd0,
    STAT_BWD        = 3'd1,
    STAT_APPENDED   = 3'd2,
    STAT_DELETED    = 3'd3,
    STAT_NOT_FOUND  = 3'd4,
    STAT_EMPTY_FULL = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_WALK,
    S_EMIT
  } state_e;

  // one result on its way to the output register
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_e           status;
    logic              last;
  } res_t;

endpackage

// ----- sv/olist_mem.sv -----
// entry storage of the ordered list: one write port, one read port
// read data registered; depends on olist_pkg
module olist_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_addr,
  input  logic [olist_pkg::DATA_W-1:0]   wr_data,
  input  logic [IDX_W-1:0]               rd_addr,
  output logic [olist_pkg::DATA_W-1:0]   rd_data
);

  logic [olist_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [olist_pkg::DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/olist_ctrl.sv -----
// sequencer of the ordered list: append, delete scan and shift, walk
// drives the entry memory and hands results on; depends on olist_pkg
module olist_ctrl #(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned IDX_W    = 5,
  parameter int unsigned CNT_W    = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request side
  input  logic                         req_valid,
  output logic                         req_ready,
  input  olist_pkg::func_e             req_func,
  input  logic [olist_pkg::DATA_W-1:0] req_value,
  // result side
  output logic                         res_valid,
  input  logic                         res_ready,
  output olist_pkg::res_t              res,
  // memory side
  output logic                         wr_en,
  output logic [IDX_W-1:0]             wr_addr,
  output logic [olist_pkg::DATA_W-1:0] wr_data,
  output logic [IDX_W-1:0]             rd_addr,
  input  logic [olist_pkg::DATA_W-1:0] rd_data
);

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

  olist_pkg::state_e            state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             ptr_r, ptr_nxt;
  logic                         dir_r, dir_nxt;
  logic [olist_pkg::DATA_W-1:0] val_r, val_nxt;
  olist_pkg::status_e           emit_st_r, emit_st_nxt;
  logic [CNT_W-1:0]             last_idx;
  logic                         at_last;
  logic                         before_last;

  assign last_idx    = count_r - CNT_W'(1);
  assign at_last     = (CNT_W'(ptr_r) == last_idx);
  assign before_last = ((CNT_W'(ptr_r) + CNT_W'(1)) == last_idx);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olist_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    dir_r     <= dir_nxt;
    val_r     <= val_nxt;
    emit_st_r <= emit_st_nxt;
  end

  // next state, memory accesses and results
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    dir_nxt     = dir_r;
    val_nxt     = val_r;
    emit_st_nxt = emit_st_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    res.value   = rd_data;
    res.status  = olist_pkg::STAT_FWD;
    res.last    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = ptr_r;
    wr_data     = rd_data;
    rd_addr     = ptr_r;

    case (state_r)
      olist_pkg::S_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = '0;
        ptr_nxt   = '0;
        dir_nxt   = 1'b0;
        if (req_valid) begin
          case (req_func)
            olist_pkg::FUNC_APPEND: begin
              val_nxt   = req_value;
              state_nxt = olist_pkg::S_EMIT;
              if (count_r == CNT_CAP) begin
                emit_st_nxt = olist_pkg::STAT_EMPTY_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = count_r[IDX_W-1:0];
                wr_data     = req_value;
                count_nxt   = count_r + CNT_W'(1);
                emit_st_nxt = olist_pkg::STAT_APPENDED;
              end
            end
            olist_pkg::FUNC_DELETE: begin
              val_nxt = req_value;
              if (count_r == '0) begin
                emit_st_nxt = olist_pkg::STAT_EMPTY_FULL;
                state_nxt   = olist_pkg::S_EMIT;
              end else begin
                state_nxt = olist_pkg::S_DEL_SCAN;
              end
            end
            olist_pkg::FUNC_WALK: begin
              if (count_r == '0) begin
                val_nxt     = '0;
                emit_st_nxt = olist_pkg::STAT_EMPTY_FULL;
                state_nxt   = olist_pkg::S_EMIT;
              end else begin
                state_nxt = olist_pkg::S_WALK;
              end
            end
            default: begin
              // unused code: dropped without a result
              state_nxt = olist_pkg::S_IDLE;
            end
          endcase
        end
      end

      // read data holds the entry at ptr
      olist_pkg::S_DEL_SCAN: begin
        if (rd_data == val_r) begin
          if (at_last) begin
            count_nxt   = count_r - CNT_W'(1);
            emit_st_nxt = olist_pkg::STAT_DELETED;
            state_nxt   = olist_pkg::S_EMIT;
          end else begin
            rd_addr   = ptr_r + IDX_W'(1);
            state_nxt = olist_pkg::S_DEL_SHIFT;
          end
        end else if (at_last) begin
          emit_st_nxt = olist_pkg::STAT_NOT_FOUND;
          state_nxt   = olist_pkg::S_EMIT;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
          rd_addr = ptr_r + IDX_W'(1);
        end
      end

      // read data holds the entry after ptr; move it up one place
      olist_pkg::S_DEL_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (before_last) begin
          count_nxt   = count_r - CNT_W'(1);
          emit_st_nxt = olist_pkg::STAT_DELETED;
          state_nxt   = olist_pkg::S_EMIT;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
          rd_addr = ptr_r + IDX_W'(2);
        end
      end

      // read data holds the entry at ptr; the read repeats while stalled
      olist_pkg::S_WALK: begin
        res_valid  = 1'b1;
        res.value  = rd_data;
        res.status = dir_r ? olist_pkg::STAT_BWD : olist_pkg::STAT_FWD;
        res.last   = dir_r && (ptr_r == '0);
        if (res_ready) begin
          if (!dir_r) begin
            if (at_last) begin
              dir_nxt = 1'b1;
            end else begin
              ptr_nxt = ptr_r + IDX_W'(1);
            end
          end else if (ptr_r == '0) begin
            state_nxt = olist_pkg::S_IDLE;
          end else begin
            ptr_nxt = ptr_r - IDX_W'(1);
          end
        end
        rd_addr = ptr_nxt;
      end

      // single result of append, delete or empty walk
      olist_pkg::S_EMIT: begin
        res_valid  = 1'b1;
        res.value  = val_r;
        res.status = emit_st_r;
        res.last   = 1'b1;
        if (res_ready) begin
          state_nxt = olist_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olist_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/olist_out.sv -----
// output register of the ordered list result channel
// parts the sequencer from the downstream stall; depends on olist_pkg
module olist_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_valid,
  output logic                         res_ready,
  input  olist_pkg::res_t              res,
  output logic                         out_valid,
  input  logic                         out_ready,
  output olist_pkg::res_t              out_res
);

  logic            valid_r, valid_nxt;
  olist_pkg::res_t res_r;

  // room when empty or when the held result leaves this cycle
  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- sv/ordered_list_append_delete_walk.sv -----
// channel  | dir | tdata            | tuser          | tlast
// in_      | in  | [31:0] value     | [1:0] func     | -
// out_     | out | [31:0] item_val  | [2:0] status   | last of request
//
// append: straight to its result; delete: scan then shift, one entry a
// cycle through the single memory read port; walk: after a registered first
// read, one result a cycle unless out_ stalls; 2*count results. in_tready
// is high only when the sequencer is idle; the output register lets a new
// request in while the last result still waits. Reset (rst_n, synchronous)
// empties the list; a stalled out_ channel holds the walk in place without loss.
// top level; depends on olist_pkg, olist_mem, olist_ctrl, olist_out
module ordered_list_append_delete_walk #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] item_value
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [olist_pkg::DATA_W-1:0] wr_data;
  logic [IDX_W-1:0]             rd_addr;
  logic [olist_pkg::DATA_W-1:0] rd_data;
  logic                         res_valid;
  logic                         res_ready;
  olist_pkg::res_t              res;
  olist_pkg::res_t              out_res;

  // entry storage
  olist_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request sequencer
  olist_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_func  (olist_pkg::func_e'(in_tuser)),
    .req_value (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // result register
  olist_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule

// ----- sv/olist_checker.sv -----
// port-level checks of the ordered list block, bound to the top level
// depends on olist_pkg and ordered_list_append_delete_walk_defines.svh
`include "ordered_list_append_delete_walk_defines.svh"

module olist_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  `OLADW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // append, delete and empty results are always the only result of a request
  `OLADW_ASSERT_IMPL(a_single_last, clk, rst_n, out_tvalid && out_tuser != olist_pkg::STAT_FWD && out_tuser != olist_pkg::STAT_BWD, out_tlast, "single result without last")

  // a forward element is never the final one
  `OLADW_ASSERT_IMPL(a_fwd_not_last, clk, rst_n, out_tvalid && out_tuser == olist_pkg::STAT_FWD, !out_tlast, "forward element marked last")

  // no new request while a walk is still running
  `OLADW_ASSERT_IMPL(a_busy_walk, clk, rst_n, out_tvalid && !out_tlast, !in_tready, "request taken during walk")

endmodule

bind ordered_list_append_delete_walk olist_checker u_olist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/ordered_list_append_delete_walk_tb.sv -----
// self-checking testbench of the ordered list block: a directed table, then phased random requests
// a behavioral list model or the directed row predicts every result, and a monitor checks each one in order
// depends on olist_pkg and ordered_list_append_delete_walk
`timescale 1ns / 100ps

module ordered_list_append_delete_walk_tb;

  localparam int unsigned CAPACITY = 32;
  localparam logic [1:0] FUNC_NONE = 2'd3;  // unused code, block ignores it
  localparam int RAND_REQUESTS = 420;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_OFF_AT = 120;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_FROM = 250;
  localparam int QUIET_TO = 330;
  localparam int MAX_REPORTS = 10;

  // random request mix, one mode per burst
  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;
  localparam int BURST_LEN = 40;

  typedef struct packed {
    logic [1:0]          func;
    logic [31:0]         value;
    logic                typed;     // expected result given in the row
    logic [31:0]         t_value;
    olist_pkg::status_e  t_status;
  } dir_row_t;

  localparam int NUM_STEPS = 24;
  localparam dir_row_t STEPS [NUM_STEPS] = '{
    '{olist_pkg::FUNC_WALK,   32'h0000_0000, 1'b1, 32'h0000_0000, olist_pkg::STAT_EMPTY_FULL},
    '{olist_pkg::FUNC_DELETE, 32'h0000_0005, 1'b1, 32'h0000_0005, olist_pkg::STAT_EMPTY_FULL},
    '{FUNC_NONE,              32'hFFFF_FFFF, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{olist_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_APPEND, 32'h8000_0000, 1'b1, 32'h8000_0000, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_APPEND, 32'h0000_0000, 1'b1, 32'h0000_0000, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_WALK,   32'h1234_5678, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{olist_pkg::FUNC_DELETE, 32'h0000_3039, 1'b1, 32'h0000_3039, olist_pkg::STAT_NOT_FOUND},
    '{olist_pkg::FUNC_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, olist_pkg::STAT_DELETED},
    '{olist_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_WALK,   32'h0000_0000, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{olist_pkg::FUNC_DELETE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, olist_pkg::STAT_DELETED},
    '{olist_pkg::FUNC_WALK,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{olist_pkg::FUNC_DELETE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, olist_pkg::STAT_DELETED},
    '{olist_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, olist_pkg::STAT_DELETED},
    '{olist_pkg::FUNC_WALK,   32'h0000_0000, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{FUNC_NONE,              32'h0000_0000, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{olist_pkg::FUNC_DELETE, 32'h8000_0000, 1'b1, 32'h8000_0000, olist_pkg::STAT_DELETED},
    '{olist_pkg::FUNC_WALK,   32'h0000_0000, 1'b1, 32'h0000_0000, olist_pkg::STAT_EMPTY_FULL},
    '{olist_pkg::FUNC_APPEND, 32'h5555_5555, 1'b1, 32'h5555_5555, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_APPEND, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, olist_pkg::STAT_APPENDED},
    '{olist_pkg::FUNC_WALK,   32'h0000_0000, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD},
    '{FUNC_NONE,              32'hAAAA_AAAA, 1'b0, 32'h0000_0000, olist_pkg::STAT_FWD}
  };

  // values that collide often, extremes among them
  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0001, 32'h0000_002A, 32'hDEAD_BEEF, 32'h0001_0000
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] item_value
  logic [2:0]  out_tuser;  // [2:0] status
  logic        out_tlast;

  logic [31:0]     list_vals [$];      // model of the list, head first
  olist_pkg::res_t pending_results [$];
  int              req_accepted = 0;
  int              rand_done = 0;
  int              mismatches = 0;
  bit              hold_done = 0;

  ordered_list_append_delete_walk #(.CAPACITY(CAPACITY)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic bit quiet_window();
    return req_accepted >= QUIET_FROM && req_accepted < QUIET_TO;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // update the list model and queue the results of one request
  function automatic void predict_list(logic [1:0] func, logic [31:0] value, bit keep);
    olist_pkg::res_t r;
    int              hit;
    int              n;
    hit = -1;
    n = list_vals.size();
    case (func)
      olist_pkg::FUNC_APPEND: begin
        if (n >= CAPACITY) begin
          r = '{value, olist_pkg::STAT_EMPTY_FULL, 1'b1};
        end else begin
          list_vals.push_back(value);
          r = '{value, olist_pkg::STAT_APPENDED, 1'b1};
        end
        if (keep) pending_results.push_back(r);
      end
      olist_pkg::FUNC_DELETE: begin
        for (int i = 0; i < n && hit < 0; i++)
          if (list_vals[i] == value) hit = i;
        if (n == 0) r = '{value, olist_pkg::STAT_EMPTY_FULL, 1'b1};
        else if (hit < 0) r = '{value, olist_pkg::STAT_NOT_FOUND, 1'b1};
        else begin
          list_vals.delete(hit);
          r = '{value, olist_pkg::STAT_DELETED, 1'b1};
        end
        if (keep) pending_results.push_back(r);
      end
      olist_pkg::FUNC_WALK: begin
        if (keep) begin
          if (n == 0) pending_results.push_back('{32'h0, olist_pkg::STAT_EMPTY_FULL, 1'b1});
          for (int i = 0; i < n; i++)
            pending_results.push_back('{list_vals[i], olist_pkg::STAT_FWD, 1'b0});
          for (int i = n - 1; i >= 0; i--)
            pending_results.push_back('{list_vals[i], olist_pkg::STAT_BWD, i == 0});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 40) return VALUE_POOL[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // offer one request, wait for its handshake, then predict it
  task automatic send_request(logic [1:0] func, logic [31:0] value, logic typed,
                              logic [31:0] t_value, olist_pkg::status_e t_status);
    int gap;
    gap = (quiet_window() || $urandom_range(0, 99) >= 34) ? 0 : $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    req_accepted++;
    predict_list(func, value, !typed);
    if (typed) pending_results.push_back('{t_value, t_status, 1'b1});
  endtask

  // receiver: random stalls, one long hold-off, one stretch without stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && req_accepted >= HOLD_OFF_AT) begin
        hold_done = 1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= quiet_window() || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    olist_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: value=%h status=%0d last=%0d",
                                out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.status || out_tlast !== want.last)
          note_mismatch($sformatf(
            "result: expected value=%h status=%0d last=%0d, got value=%h status=%0d last=%0d",
            want.value, want.status, want.last, out_tdata, out_tuser, out_tlast));
      end
    end
  end

  // stimulus
  initial begin
    int          mode;
    int          burst;
    int          roll;
    bit          first_burst;
    logic [1:0]  func;
    logic [31:0] value;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_STEPS; i++)
      send_request(STEPS[i].func, STEPS[i].value, STEPS[i].typed, STEPS[i].t_value,
                   STEPS[i].t_status);

    // random bursts; the first one fills the list past capacity
    burst = 0;
    first_burst = 1;
    mode = MODE_GROW;
    while (rand_done < RAND_REQUESTS) begin
      if (burst == 0) begin
        mode = first_burst ? MODE_GROW : $urandom_range(MODE_GROW, MODE_MIXED);
        first_burst = 0;
        burst = BURST_LEN;
      end
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_GROW:   func = roll < 88 ? olist_pkg::FUNC_APPEND :
                            roll < 93 ? olist_pkg::FUNC_DELETE :
                            roll < 98 ? olist_pkg::FUNC_WALK : FUNC_NONE;
        MODE_SHRINK: func = roll < 15 ? olist_pkg::FUNC_APPEND :
                            roll < 85 ? olist_pkg::FUNC_DELETE :
                            roll < 97 ? olist_pkg::FUNC_WALK : FUNC_NONE;
        default:     func = roll < 45 ? olist_pkg::FUNC_APPEND :
                            roll < 80 ? olist_pkg::FUNC_DELETE :
                            roll < 97 ? olist_pkg::FUNC_WALK : FUNC_NONE;
      endcase
      // deletes mostly aim at a value that is held
      if (func == olist_pkg::FUNC_DELETE && list_vals.size() > 0 && $urandom_range(0, 99) < 75)
        value = list_vals[$urandom_range(0, list_vals.size() - 1)];
      else
        value = pick_value();
      send_request(func, value, 1'b0, 32'h0, olist_pkg::STAT_FWD);
      if (func != FUNC_NONE) rand_done++;
      burst--;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then allow late extra results to show up
    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
